[rtl/core/ccr_pkg.sv]
// Shared widths, defaults and result codes for the clock counter replacement block.
// No dependencies.
`default_nettype none
package ccr_pkg;
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 21;
    localparam int BYTES_W = 40;
    localparam int CTR_W   = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_ENTRIES = 32;

    localparam logic [BYTES_W-1:0] CAP_RESET = 40'd1048576;
    localparam logic [CTR_W-1:0]   MAXC_RESET = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CTR  = 1'd1;

    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISS   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    typedef struct packed {
        logic [BYTES_W-1:0] capacity;
        logic [CTR_W-1:0]   max_ctr;
    } ccr_cfg_t;
endpackage
`default_nettype wire

[rtl/core/ccr_ifs.sv]
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on ccr_pkg.
`default_nettype none
interface ccr_req_if import ccr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  req_key;
    logic [SIZE_W-1:0] req_size;
    modport source (output valid, req_key, req_size, input ready);
    modport sink   (input valid, req_key, req_size, output ready);
endinterface

interface ccr_rsp_if import ccr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key_out;
    logic               forced;
    logic [BYTES_W-1:0] bytes_cached;
    logic               last;
    modport source (output valid, kind, key_out, forced, bytes_cached, last, input ready);
    modport sink   (input valid, kind, key_out, forced, bytes_cached, last, output ready);
endinterface

interface ccr_cfg_if import ccr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTES_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/ccr_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module ccr_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/ccr_cfg.sv]
// Configuration register file: capacity and maximum counter value.
// Depends on ccr_pkg and ccr_ifs.
`default_nettype none
module ccr_cfg import ccr_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ccr_cfg_if.sink    cfg_ch,
    output ccr_cfg_t   cfg
);
    logic [BYTES_W-1:0] cap_reg;
    logic [CTR_W-1:0]   maxc_reg;

    assign cfg_ch.ready = 1'b1;
    assign cfg.capacity = cap_reg;
    assign cfg.max_ctr  = maxc_reg;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            maxc_reg <= MAXC_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_CAPACITY: cap_reg  <= cfg_ch.data;
                REG_MAX_CTR:  maxc_reg <= cfg_ch.data[CTR_W-1:0];
                default:      ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/clock_counter_replacement.sv]
// CLOCK replacement with multi-bit counters; one sequencer over slot RAMs.
// The sequencer scans every slot's key, then decides; a hit or reject result is loaded from the decide state.
// A resize first removes the old entry, each eviction sweeps from the hand, then the new entry is inserted.
// One request at a time: the RAM read port and the hand sweep set the rate.
// Reset (async, rst_n low) empties the table, clears hand, bytes and eviction flag.
`default_nettype none
module clock_counter_replacement import ccr_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ccr_req_if.sink   req_ch,
    ccr_rsp_if.source rsp_ch,
    ccr_cfg_if.sink   cfg_ch
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_RM_RD  = 4'd3;
    localparam logic [3:0] S_RM     = 4'd4;
    localparam logic [3:0] S_EVCHK  = 4'd5;
    localparam logic [3:0] S_EV_RD  = 4'd6;
    localparam logic [3:0] S_EV     = 4'd7;
    localparam logic [3:0] S_VIC_RD = 4'd8;
    localparam logic [3:0] S_VIC    = 4'd9;
    localparam logic [3:0] S_INS_RD = 4'd10;
    localparam logic [3:0] S_INS1   = 4'd11;
    localparam logic [3:0] S_INS2   = 4'd12;

    ccr_cfg_t cfg;

    ccr_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .cfg(cfg));

    logic [3:0]         state_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [CW-1:0]      sc_reg;
    logic               found_reg;
    logic [IW-1:0]      fidx_reg;
    logic [SIZE_W-1:0]  fsize_reg;
    logic [IW-1:0]      free_reg;
    logic               free_ok_reg;
    logic [IW-1:0]      hand_reg;
    logic [BYTES_W-1:0] used_reg;
    logic [CW-1:0]      cnt_reg;
    logic               evo_reg;
    logic [IW-1:0]      p_reg;
    logic [CW-1:0]      lap_reg;
    logic [IW-1:0]      vic_reg;
    logic               forced_reg;
    logic [IW-1:0]      pins_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic               ovld_reg;
    logic [KIND_W-1:0]  okind_reg;
    logic [KEY_W-1:0]   okey_reg;
    logic               oforced_reg;
    logic [BYTES_W-1:0] obytes_reg;
    logic               olast_reg;

    // RAM ports
    logic [IW-1:0]      ra;
    logic [KEY_W-1:0]   key_rd;
    logic [SIZE_W-1:0]  size_rd;
    logic [CTR_W-1:0]   ctr_rd;
    logic [IW-1:0]      next_rd;
    logic [IW-1:0]      prev_rd;
    logic               kw_we, cw_we, nw_we, pw_we;
    logic [IW-1:0]      cw_addr, nw_addr, pw_addr;
    logic [CTR_W-1:0]   cw_data;
    logic [IW-1:0]      nw_data, pw_data;

    logic               emit_ok;
    logic [IW-1:0]      scan_idx;
    logic               is_hit;
    logic               too_big;
    logic               rsp_load;
    logic [IW-1:0]      p_use;
    logic [BYTES_W:0]   need;

    assign emit_ok  = !ovld_reg || rsp_ch.ready;
    assign scan_idx = IW'(sc_reg - CW'(1));
    assign is_hit   = found_reg && (fsize_reg == size_reg);
    assign too_big  = {{(BYTES_W - SIZE_W){1'b0}}, size_reg} > cfg.capacity;
    assign rsp_load = emit_ok && (((state_reg == S_DECIDE) && (is_hit || too_big)) ||
                                  (state_reg == S_VIC) || (state_reg == S_INS2));
    assign p_use    = (cnt_reg == '0) ? free_reg : prev_rd;
    assign need     = {1'b0, used_reg} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_reg};

    assign req_ch.ready        = (state_reg == S_IDLE);
    assign rsp_ch.valid        = ovld_reg;
    assign rsp_ch.kind         = okind_reg;
    assign rsp_ch.key_out      = okey_reg;
    assign rsp_ch.forced       = oforced_reg;
    assign rsp_ch.bytes_cached = obytes_reg;
    assign rsp_ch.last         = olast_reg;

    // Select the shared read address
    always_comb
    begin
        case (state_reg)
            S_SCAN:           ra = (sc_reg < FULL) ? sc_reg[IW-1:0] : '0;
            S_RM_RD, S_RM:    ra = fidx_reg;
            S_EV_RD, S_EV:    ra = p_reg;
            S_VIC_RD, S_VIC:  ra = vic_reg;
            S_INS_RD, S_INS1: ra = hand_reg;
            default:          ra = '0;
        endcase
    end

    // Select the write ports
    always_comb
    begin
        kw_we   = 1'b0;
        cw_we   = 1'b0;
        nw_we   = 1'b0;
        pw_we   = 1'b0;
        cw_addr = free_reg;
        cw_data = evo_reg ? cfg.max_ctr : '0;
        nw_addr = prev_rd;
        nw_data = next_rd;
        pw_addr = next_rd;
        pw_data = prev_rd;
        case (state_reg)
            S_DECIDE:
            begin
                cw_we   = is_hit && emit_ok;
                cw_addr = fidx_reg;
                cw_data = cfg.max_ctr;
            end
            S_RM:
            begin
                nw_we = 1'b1;
                pw_we = 1'b1;
            end
            S_EV:
            begin
                cw_we   = (ctr_rd != '0);
                cw_addr = p_reg;
                cw_data = ctr_rd - CTR_W'(1);
            end
            S_VIC:
            begin
                nw_we = emit_ok;
                pw_we = emit_ok;
            end
            S_INS1:
            begin
                nw_we   = 1'b1;
                nw_addr = free_reg;
                nw_data = hand_reg;
                pw_we   = 1'b1;
                pw_addr = free_reg;
                pw_data = p_use;
            end
            S_INS2:
            begin
                kw_we   = emit_ok;
                cw_we   = emit_ok;
                nw_we   = emit_ok;
                nw_addr = pins_reg;
                nw_data = free_reg;
                pw_we   = emit_ok;
                pw_addr = hand_reg;
                pw_data = free_reg;
            end
            default: ;
        endcase
    end

    ccr_ram #(.W(KEY_W), .D(ENTRIES)) u_key (.clk(clk), .we(kw_we), .waddr(free_reg),
        .wdata(key_reg), .raddr(ra), .rdata(key_rd));
    ccr_ram #(.W(SIZE_W), .D(ENTRIES)) u_size (.clk(clk), .we(kw_we), .waddr(free_reg),
        .wdata(size_reg), .raddr(ra), .rdata(size_rd));
    ccr_ram #(.W(CTR_W), .D(ENTRIES)) u_ctr (.clk(clk), .we(cw_we), .waddr(cw_addr),
        .wdata(cw_data), .raddr(ra), .rdata(ctr_rd));
    ccr_ram #(.W(IW), .D(ENTRIES)) u_next (.clk(clk), .we(nw_we), .waddr(nw_addr),
        .wdata(nw_data), .raddr(ra), .rdata(next_rd));
    ccr_ram #(.W(IW), .D(ENTRIES)) u_prev (.clk(clk), .we(pw_we), .waddr(pw_addr),
        .wdata(pw_data), .raddr(ra), .rdata(prev_rd));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            key_reg     <= '0;
            size_reg    <= '0;
            sc_reg      <= '0;
            found_reg   <= 1'b0;
            fidx_reg    <= '0;
            fsize_reg   <= '0;
            free_reg    <= '0;
            free_ok_reg <= 1'b0;
            hand_reg    <= '0;
            used_reg    <= '0;
            cnt_reg     <= '0;
            evo_reg     <= 1'b0;
            p_reg       <= '0;
            lap_reg     <= '0;
            vic_reg     <= '0;
            forced_reg  <= 1'b0;
            pins_reg    <= '0;
            valid_reg   <= '0;
            ovld_reg    <= 1'b0;
            okind_reg   <= KIND_MISS;
            okey_reg    <= '0;
            oforced_reg <= 1'b0;
            obytes_reg  <= '0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            // Drop a taken result unless a new one loads
            if (ovld_reg && rsp_ch.ready && !rsp_load)
            begin
                ovld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_ch.valid)
                    begin
                        key_reg     <= req_ch.req_key;
                        size_reg    <= req_ch.req_size;
                        sc_reg      <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (sc_reg != '0)
                    begin
                        if (valid_reg[scan_idx] && key_rd == key_reg && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            fidx_reg  <= scan_idx;
                            fsize_reg <= size_rd;
                        end
                        if (!valid_reg[scan_idx] && !free_ok_reg)
                        begin
                            free_reg    <= scan_idx;
                            free_ok_reg <= 1'b1;
                        end
                    end
                    if (sc_reg == FULL)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        sc_reg <= sc_reg + CW'(1);
                    end
                end
                S_DECIDE:
                begin
                    if (is_hit || too_big)
                    begin
                        if (emit_ok)
                        begin
                            ovld_reg    <= 1'b1;
                            okind_reg   <= is_hit ? KIND_HIT : KIND_REJECT;
                            okey_reg    <= key_reg;
                            oforced_reg <= 1'b0;
                            obytes_reg  <= used_reg;
                            olast_reg   <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end
                    else if (found_reg)
                    begin
                        state_reg <= S_RM_RD;
                    end
                    else
                    begin
                        state_reg <= S_EVCHK;
                    end
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM;
                end
                S_RM:
                begin
                    // Remove the resized entry
                    if (hand_reg == fidx_reg)
                    begin
                        hand_reg <= next_rd;
                    end
                    valid_reg[fidx_reg] <= 1'b0;
                    used_reg <= used_reg - {{(BYTES_W - SIZE_W){1'b0}}, fsize_reg};
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (!free_ok_reg || fidx_reg < free_reg)
                    begin
                        free_reg    <= fidx_reg;
                        free_ok_reg <= 1'b1;
                    end
                    state_reg <= S_EVCHK;
                end
                S_EVCHK:
                begin
                    if (cnt_reg != '0 &&
                        (need > {1'b0, cfg.capacity} || cnt_reg == FULL))
                    begin
                        evo_reg   <= 1'b1;
                        p_reg     <= hand_reg;
                        lap_reg   <= '0;
                        state_reg <= S_EV_RD;
                    end
                    else if (cnt_reg == '0)
                    begin
                        hand_reg  <= free_reg;
                        pins_reg  <= free_reg;
                        state_reg <= S_INS1;
                    end
                    else
                    begin
                        state_reg <= S_INS_RD;
                    end
                end
                S_EV_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    // Advance the hand or pick the victim
                    if (ctr_rd == '0)
                    begin
                        vic_reg    <= p_reg;
                        forced_reg <= 1'b0;
                        state_reg  <= S_VIC_RD;
                    end
                    else if (lap_reg + CW'(1) == cnt_reg)
                    begin
                        vic_reg    <= hand_reg;
                        forced_reg <= 1'b1;
                        state_reg  <= S_VIC_RD;
                    end
                    else
                    begin
                        lap_reg   <= lap_reg + CW'(1);
                        p_reg     <= next_rd;
                        state_reg <= S_EV_RD;
                    end
                end
                S_VIC_RD:
                begin
                    state_reg <= S_VIC;
                end
                S_VIC:
                begin
                    if (emit_ok)
                    begin
                        hand_reg <= next_rd;
                        valid_reg[vic_reg] <= 1'b0;
                        used_reg <= used_reg - {{(BYTES_W - SIZE_W){1'b0}}, size_rd};
                        cnt_reg  <= cnt_reg - CW'(1);
                        if (!free_ok_reg || vic_reg < free_reg)
                        begin
                            free_reg    <= vic_reg;
                            free_ok_reg <= 1'b1;
                        end
                        ovld_reg    <= 1'b1;
                        okind_reg   <= KIND_VICTIM;
                        okey_reg    <= key_rd;
                        oforced_reg <= forced_reg;
                        obytes_reg  <= used_reg - {{(BYTES_W - SIZE_W){1'b0}}, size_rd};
                        olast_reg   <= 1'b0;
                        state_reg   <= S_EVCHK;
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS1;
                end
                S_INS1:
                begin
                    pins_reg  <= p_use;
                    state_reg <= S_INS2;
                end
                S_INS2:
                begin
                    if (emit_ok)
                    begin
                        valid_reg[free_reg] <= 1'b1;
                        cnt_reg     <= cnt_reg + CW'(1);
                        used_reg    <= need[BYTES_W-1:0];
                        ovld_reg    <= 1'b1;
                        okind_reg   <= KIND_MISS;
                        okey_reg    <= key_reg;
                        oforced_reg <= 1'b0;
                        obytes_reg  <= need[BYTES_W-1:0];
                        olast_reg   <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[test/ccr_tb_ifs.sv]
// Testbench-side note: channel interfaces come from the RTL file ccr_ifs.sv.
// This file holds the cache-content scoreboard class; depends on ccr_pkg.
`default_nettype none
package ccr_tb_pkg;
    import ccr_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key_out;
        logic               forced;
        logic [BYTES_W-1:0] bytes_cached;
        logic               last;
    } outcome_t;

    class clock_cache_board;
        localparam int N = DEF_ENTRIES;
        bit [BYTES_W-1:0]  capacity;
        bit [CTR_W-1:0]    max_ctr;
        bit                live [N];
        bit [KEY_W-1:0]    tag [N];
        bit [SIZE_W-1:0]   bytes [N];
        bit [CTR_W-1:0]    ctr [N];
        int unsigned       succ [N];
        int unsigned       pred [N];
        int unsigned       hand;
        bit [BYTES_W-1:0]  held;
        bit                ever_evicted;
        outcome_t          pending [$];
        int                errors;

        function new();
            capacity = CAP_RESET;
            max_ctr = MAXC_RESET;
            foreach (live[i]) live[i] = 0;
            hand = 0;
            held = 0;
            ever_evicted = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] val);
            if (idx == REG_CAPACITY)
                capacity = val;
            else
                max_ctr = val[CTR_W-1:0];
        endfunction

        function void drop_slot(int unsigned s);
            succ[pred[s]] = succ[s];
            pred[succ[s]] = pred[s];
            live[s] = 0;
            held = held - bytes[s];
        endfunction

        function void push(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key, bit f, bit l);
            outcome_t o;
            o.kind = k;
            o.key_out = key;
            o.forced = f;
            o.bytes_cached = held;
            o.last = l;
            pending.push_back(o);
        endfunction

        // Predict every result of one accepted request.
        function void note_request(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] sz);
            int found;
            int unsigned cnt, p, victim, s;
            bit got_zero;
            found = -1;
            for (int i = 0; i < N; i++)
                if (found < 0 && live[i] && tag[i] == key)
                    found = i;
            if (found >= 0 && bytes[found] == sz) begin
                ctr[found] = max_ctr;
                push(KIND_HIT, key, 0, 1);
                return;
            end
            if ({19'd0, sz} > capacity) begin
                push(KIND_REJECT, key, 0, 1);
                return;
            end
            if (found >= 0) begin
                if (hand == found)
                    hand = succ[found];
                drop_slot(found);
            end
            cnt = 0;
            foreach (live[i]) if (live[i]) cnt++;
            // Sweep at most one lap per eviction.
            while (cnt > 0 && ({1'b0, held} + sz > {1'b0, capacity} || cnt >= N)) begin
                p = hand;
                got_zero = 0;
                victim = 0;
                ever_evicted = 1;
                for (int i = 0; i < cnt; i++) begin
                    if (!got_zero) begin
                        if (ctr[p] == 0) begin
                            victim = p;
                            got_zero = 1;
                        end
                        else begin
                            ctr[p] = ctr[p] - CTR_W'(1);
                            p = succ[p];
                        end
                    end
                end
                if (!got_zero)
                    victim = hand;
                hand = succ[victim];
                drop_slot(victim);
                cnt--;
                push(KIND_VICTIM, tag[victim], !got_zero, 0);
            end
            s = N;
            for (int i = N - 1; i >= 0; i--)
                if (!live[i]) s = i;
            s = s % N;
            live[s] = 1;
            tag[s] = key;
            bytes[s] = sz;
            ctr[s] = ever_evicted ? max_ctr : '0;
            if (cnt == 0) begin
                succ[s] = s;
                pred[s] = s;
                hand = s;
            end
            else begin
                p = pred[hand];
                succ[s] = hand;
                pred[s] = p;
                succ[p] = s;
                pred[hand] = s;
            end
            held = held + sz;
            push(KIND_MISS, key, 0, 1);
        endfunction

        function void report(string what);
            $display("result error: %s", what);
            errors++;
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.key_out !== want.key_out)
                report($sformatf("key_out %h want %h", got.key_out, want.key_out));
            if (got.forced !== want.forced)
                report($sformatf("forced %b want %b", got.forced, want.forced));
            if (got.bytes_cached !== want.bytes_cached)
                report($sformatf("bytes %0d want %0d", got.bytes_cached, want.bytes_cached));
            if (got.last !== want.last)
                report($sformatf("last %b want %b", got.last, want.last));
        endfunction
    endclass
endpackage
`default_nettype wire

[test/testbench.sv]
// Top-level test of clock_counter_replacement: directed and random cache requests.
// Depends on ccr_pkg, the RTL channel interfaces and ccr_tb_pkg.
`default_nettype none
module testbench;
    import ccr_pkg::*;
    import ccr_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    clock_cache_board board;

    ccr_req_if req_ch ();
    ccr_rsp_if rsp_ch ();
    ccr_cfg_if cfg_ch ();

    clock_counter_replacement i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch.sink),
        .rsp_ch (rsp_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("clock_counter_replacement: mismatch");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Take results with random stalls on ready.
    initial
    begin
        outcome_t got;
        rsp_ch.ready = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.kind = rsp_ch.kind;
                got.key_out = rsp_ch.key_out;
                got.forced = rsp_ch.forced;
                got.bytes_cached = rsp_ch.bytes_cached;
                got.last = rsp_ch.last;
                board.check_result(got);
            end
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Wait a random gap after the previous request drops valid, then hold valid until ready.
    task automatic send_request(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] sz);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge clk);
        req_ch.valid <= 1;
        req_ch.req_key <= key;
        req_ch.req_size <= sz;
        do @(posedge clk); while (!req_ch.ready);
        board.note_request(key, sz);
        req_ch.valid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] val);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_reg(idx, val);
        cfg_ch.valid <= 0;
    endtask

    // Keys from a small pool so hits and resizes happen often.
    task automatic random_phase(int n, int pool, int unsigned max_sz);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = KEY_W'($urandom_range(0, pool - 1));
            if ($urandom_range(0, 19) == 0)
                send_request(k, SIZE_W'($urandom_range(0, 21'h1FFFFF)));
            else
                send_request(k, SIZE_W'($urandom_range(0, max_sz)));
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        req_ch.valid = 0;
        req_ch.req_key = 0;
        req_ch.req_size = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_CAPACITY;
        cfg_ch.data = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, zero size, hit, resize, oversize.
        send_request(32'h0, 21'd0);
        send_request(32'hFFFF_FFFF, 21'd1048576);
        send_request(32'h0, 21'd0);
        send_request(32'hFFFF_FFFF, 21'd5);
        send_request(32'hAAAA_5555, 21'h1FFFFF);
        send_request(32'h5555_AAAA, 21'd1048576);
        send_request(32'h5555_AAAA, 21'd1048576);
        // Fill the table past its slot count to force slot evictions.
        for (int i = 0; i < 34; i++)
            send_request(KEY_W'(100 + i), 21'd1);
        drain();

        // Small capacity, low counter: dense evictions.
        write_reg(REG_CAPACITY, 40'd1);
        write_reg(REG_MAX_CTR, 40'd1);
        send_request(7, 21'd1);
        send_request(8, 21'd2);
        write_reg(REG_CAPACITY, 40'd64);
        random_phase(25, 24, 20);
        drain();

        write_reg(REG_CAPACITY, 40'hFF_FFFF_FFFF);
        write_reg(REG_MAX_CTR, 40'd15);
        random_phase(25, 48, 21'h1FFFFF);

        write_reg(REG_CAPACITY, 40'd3000);
        write_reg(REG_MAX_CTR, 40'd3);
        random_phase(20, 40, 400);

        drain();
        if (board.errors == 0)
            $display("clock_counter_replacement: match");
        else
            $display("clock_counter_replacement: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
